// ===== rtl/core/chtc_pkg.sv =====
// Shared types, constants and calibration tables of the hit time clusterer.
package chtc_pkg;

  // Default values of the top level parameters.
  localparam int GAIN_FRAC_BITS_DEF   = 8;
  localparam int ENERGY_FRAC_BITS_DEF = 4;
  localparam int TIME_WIDTH_DEF       = 16;

  // Fixed field widths of the ports.
  localparam int HIT_TIME_W = 16;
  localparam int RAW_W      = 17;
  localparam int CHANNEL_W  = 5;
  localparam int TAG_W      = 16;
  localparam int SUM_W      = 32;
  localparam int FLOOR_W    = 24;
  localparam int NUM_CHANNELS = 1 << CHANNEL_W;

  // Configuration port.
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_TIME_GATE_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_GATE_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_WINDOW = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_FLOOR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_LIMIT      = 3'd4;

  localparam logic [HIT_TIME_W-1:0] TIME_GATE_LOW_RST  = 16'd100;
  localparam logic [HIT_TIME_W-1:0] TIME_GATE_HIGH_RST = 16'd2000;
  localparam logic [HIT_TIME_W-1:0] CLUSTER_WINDOW_RST = 16'd60;
  localparam logic [FLOOR_W-1:0]    ENERGY_FLOOR_RST   = 24'd1600;
  localparam logic [RAW_W-1:0]      RAW_LIMIT_RST      = 17'd100000;

  // Result queue sizing.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // One cluster as it leaves the block.
  typedef struct packed {
    logic [HIT_TIME_W-1:0] cluster_time;
    logic [SUM_W-1:0]      back_energy;
    logic [SUM_W-1:0]      front_energy;
    logic [TAG_W-1:0]      cluster_event;
    logic                  last_of_run;
  } result_t;

  // Up to two clusters produced by one hit, first one first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  // Width of a calibrated energy for a given number of fraction bits.
  function automatic int energy_width(input int efb);
    return 21 + efb;
  endfunction

  // Width used to compare times against the 16 bit gate registers.
  function automatic int cmp_width(input int tw);
    return (tw > HIT_TIME_W) ? tw : HIT_TIME_W;
  endfunction

  // Gain per channel in hundredths; unlisted channels use the default entry.
  function automatic int gain_hundredths(input int ch);
    int g;
    case (ch)
      1:       g = 174;
      2:       g = 194;
      3:       g = 182;
      4:       g = 186;
      5:       g = 188;
      6:       g = 265;
      7:       g = 192;
      8:       g = 200;
      9:       g = 210;
      10:      g = 252;
      17:      g = 190;
      18:      g = 181;
      19:      g = 190;
      20:      g = 200;
      21:      g = 196;
      22:      g = 195;
      23:      g = 180;
      default: g = 194;
    endcase
    return g;
  endfunction

  // Offset per channel in hundredths of keV.
  function automatic int offset_hundredths(input int ch);
    int o;
    case (ch)
      1:       o = 1246;
      2:       o = 1034;
      3:       o = 1170;
      4:       o = 2230;
      5:       o = 2078;
      6:       o = 1341;
      7:       o = 1303;
      8:       o = 1492;
      9:       o = 1337;
      10:      o = 1316;
      17:      o = 2451;
      18:      o = 3433;
      19:      o = 3227;
      20:      o = 5030;
      21:      o = 8273;
      22:      o = 3343;
      23:      o = 3241;
      default: o = 2770;
    endcase
    return o;
  endfunction

  // Fixed point gain, rounded half up.
  function automatic int gain_q(input int ch, input int frac);
    return ((gain_hundredths(ch) << frac) + 50) / 100;
  endfunction

  // Fixed point offset, rounded half up.
  function automatic int offset_q(input int ch, input int frac);
    return ((offset_hundredths(ch) << frac) + 50) / 100;
  endfunction

  // Unsigned add that sticks at all ones.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ===== rtl/core/calibrated_hit_time_clusterer_core.sv =====
// Top level of the calibrated hit time clusterer.
//
// Hits of one event enter on the input channel (in_valid / in_stall), sorted
// by time, one per cycle. Each hit passes an input register, one stage that
// calibrates it and applies the raw limit, time gate and energy floor, and
// one stage that joins it to the open cluster or closes that cluster. Closed
// clusters go to a four-entry queue that drives the output channel
// (out_valid / out_stall). A hit may produce up to two clusters: the one it
// closes and, with end_of_event set, the one it flushes; last_of_run marks
// the last of them.
// The hit that produces a cluster passes the input register and the calibrated
// hit register, and the cluster is then written into the queue. Throughput: one
// hit per cycle while the output drains at least one cluster per cycle; the
// single output port sets the limit when hits close and flush clusters in one
// cycle. in_stall rises when the queue holds more than two clusters, so a
// stalled receiver backs up into the input without losing data.
// Reset clears the pipeline, the queue and the cluster state, and loads the
// default configuration. The user must write registers through cfg_write
// only while the block is idle; the block does not enforce this.
module calibrated_hit_time_clusterer_core #(
  parameter int GAIN_FRAC_BITS   = chtc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ENERGY_FRAC_BITS = chtc_pkg::ENERGY_FRAC_BITS_DEF,
  parameter int TIME_WIDTH       = chtc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [chtc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [chtc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [chtc_pkg::HIT_TIME_W-1:0]      hit_time,
  input  logic [chtc_pkg::RAW_W-1:0]           raw_energy,
  input  logic [chtc_pkg::CHANNEL_W-1:0]       channel,
  input  logic [chtc_pkg::TAG_W-1:0]           event_tag,
  input  logic                                 end_of_event,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [chtc_pkg::HIT_TIME_W-1:0]      cluster_time,
  output logic [chtc_pkg::SUM_W-1:0]           back_energy,
  output logic [chtc_pkg::SUM_W-1:0]           front_energy,
  output logic [chtc_pkg::TAG_W-1:0]           cluster_event,
  output logic                                 last_of_run
);
  import chtc_pkg::*;

  localparam int E_W = energy_width(ENERGY_FRAC_BITS);

  // Configuration registers.
  logic [HIT_TIME_W-1:0] time_gate_low;
  logic [HIT_TIME_W-1:0] time_gate_high;
  logic [HIT_TIME_W-1:0] cluster_window;
  logic [FLOOR_W-1:0]    energy_floor;
  logic [RAW_W-1:0]      raw_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_gate_low  <= TIME_GATE_LOW_RST;
      time_gate_high <= TIME_GATE_HIGH_RST;
      cluster_window <= CLUSTER_WINDOW_RST;
      energy_floor   <= ENERGY_FLOOR_RST;
      raw_limit      <= RAW_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_GATE_LOW:  time_gate_low  <= cfg_data[HIT_TIME_W-1:0];
        REG_TIME_GATE_HIGH: time_gate_high <= cfg_data[HIT_TIME_W-1:0];
        REG_CLUSTER_WINDOW: cluster_window <= cfg_data[HIT_TIME_W-1:0];
        REG_ENERGY_FLOOR:   energy_floor   <= cfg_data[FLOOR_W-1:0];
        REG_RAW_LIMIT:      raw_limit      <= cfg_data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together while the queue has room.
  logic advance;
  assign in_stall = !advance;

  logic                  cal_valid;
  logic                  cal_keep;
  logic                  cal_back;
  logic [E_W-1:0]        cal_energy;
  logic [TIME_WIDTH-1:0] cal_time;
  logic [TAG_W-1:0]      cal_tag;
  logic                  cal_eoe;
  result_pair_t          pair;
  result_t               head;

  chtc_calib #(
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
    .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS),
    .TIME_WIDTH       (TIME_WIDTH)
  ) u_calib (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .in_valid       (in_valid),
    .hit_time       (hit_time),
    .raw_energy     (raw_energy),
    .channel        (channel),
    .event_tag      (event_tag),
    .end_of_event   (end_of_event),
    .time_gate_low  (time_gate_low),
    .time_gate_high (time_gate_high),
    .energy_floor   (energy_floor),
    .raw_limit      (raw_limit),
    .cal_valid      (cal_valid),
    .cal_keep       (cal_keep),
    .cal_back       (cal_back),
    .cal_energy     (cal_energy),
    .cal_time       (cal_time),
    .cal_tag        (cal_tag),
    .cal_eoe        (cal_eoe)
  );

  chtc_cluster #(
    .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS),
    .TIME_WIDTH       (TIME_WIDTH)
  ) u_cluster (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .cal_valid      (cal_valid),
    .cal_keep       (cal_keep),
    .cal_back       (cal_back),
    .cal_energy     (cal_energy),
    .cal_time       (cal_time),
    .cal_tag        (cal_tag),
    .cal_eoe        (cal_eoe),
    .cluster_window (cluster_window),
    .pair           (pair)
  );

  chtc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .space     (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Output fields come straight from the head of the queue.
  assign cluster_time  = head.cluster_time;
  assign back_energy   = head.back_energy;
  assign front_energy  = head.front_energy;
  assign cluster_event = head.cluster_event;
  assign last_of_run   = head.last_of_run;

endmodule

// ===== rtl/core/chtc_calib.sv =====
// Input register, per-channel calibration and hit selection stage.
module chtc_calib #(
  parameter int GAIN_FRAC_BITS   = chtc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ENERGY_FRAC_BITS = chtc_pkg::ENERGY_FRAC_BITS_DEF,
  parameter int TIME_WIDTH       = chtc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   advance,
  input  logic                                   in_valid,
  input  logic [chtc_pkg::HIT_TIME_W-1:0]        hit_time,
  input  logic [chtc_pkg::RAW_W-1:0]             raw_energy,
  input  logic [chtc_pkg::CHANNEL_W-1:0]         channel,
  input  logic [chtc_pkg::TAG_W-1:0]             event_tag,
  input  logic                                   end_of_event,
  input  logic [chtc_pkg::HIT_TIME_W-1:0]        time_gate_low,
  input  logic [chtc_pkg::HIT_TIME_W-1:0]        time_gate_high,
  input  logic [chtc_pkg::FLOOR_W-1:0]           energy_floor,
  input  logic [chtc_pkg::RAW_W-1:0]             raw_limit,
  output logic                                   cal_valid,
  output logic                                   cal_keep,
  output logic                                   cal_back,
  output logic [ENERGY_FRAC_BITS+20:0]           cal_energy,
  output logic [TIME_WIDTH-1:0]                  cal_time,
  output logic [chtc_pkg::TAG_W-1:0]             cal_tag,
  output logic                                   cal_eoe
);
  import chtc_pkg::*;

  localparam int GQ_W   = GAIN_FRAC_BITS + 2;
  localparam int OQ_W   = ENERGY_FRAC_BITS + 7;
  localparam int PROD_W = RAW_W + GQ_W;
  localparam int RND_W  = PROD_W + ENERGY_FRAC_BITS + 1;
  localparam int E_W    = energy_width(ENERGY_FRAC_BITS);
  localparam int CMP_W  = cmp_width(TIME_WIDTH);

  // Input register.
  logic                  h_valid;
  logic [HIT_TIME_W-1:0] h_time;
  logic [RAW_W-1:0]      h_raw;
  logic [CHANNEL_W-1:0]  h_ch;
  logic [TAG_W-1:0]      h_tag;
  logic                  h_eoe;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (advance) begin
      h_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      h_time <= hit_time;
      h_raw  <= raw_energy;
      h_ch   <= channel;
      h_tag  <= event_tag;
      h_eoe  <= end_of_event;
    end
  end

  // Constant gain and offset tables indexed by channel.
  logic [GQ_W-1:0] gq_tab [NUM_CHANNELS];
  logic [OQ_W-1:0] oq_tab [NUM_CHANNELS];

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_tab
    localparam int GQ = gain_q(c, GAIN_FRAC_BITS);
    localparam int OQ = offset_q(c, ENERGY_FRAC_BITS);
    assign gq_tab[c] = GQ_W'(GQ);
    assign oq_tab[c] = OQ_W'(OQ);
  end

  // Calibrated energy: scale, round off the gain fraction, add the offset.
  logic [PROD_W-1:0]     prod;
  logic [RND_W-1:0]      rounded;
  logic [E_W-1:0]        energy;
  logic [TIME_WIDTH-1:0] t_w;
  logic [CMP_W-1:0]      t_c;
  logic                  back;
  logic                  keep;

  assign prod    = PROD_W'(h_raw) * PROD_W'(gq_tab[h_ch]);
  assign rounded = (RND_W'(prod) << ENERGY_FRAC_BITS)
                 + (RND_W'(1) << (GAIN_FRAC_BITS - 1));
  assign energy  = E_W'(rounded >> GAIN_FRAC_BITS) + E_W'(oq_tab[h_ch]);

  // Channels one to ten sit on the back side.
  assign back = h_ch inside {[5'd1:5'd10]};

  // Raw limit, time gate and energy floor.
  assign t_w  = TIME_WIDTH'(h_time);
  assign t_c  = CMP_W'(t_w);
  assign keep = (h_raw < raw_limit)
             && (t_c > CMP_W'(time_gate_low))
             && (t_c <= CMP_W'(time_gate_high))
             && (SUM_W'(energy) > SUM_W'(energy_floor));

  // Calibrated hit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_valid <= 1'b0;
    end else if (advance) begin
      cal_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && h_valid) begin
      cal_keep   <= keep;
      cal_back   <= back;
      cal_energy <= energy;
      cal_time   <= t_w;
      cal_tag    <= h_tag;
      cal_eoe    <= h_eoe;
    end
  end

endmodule

// ===== rtl/core/chtc_cluster.sv =====
// Open cluster state, window test, saturating sums and cluster emission.
module chtc_cluster #(
  parameter int ENERGY_FRAC_BITS = chtc_pkg::ENERGY_FRAC_BITS_DEF,
  parameter int TIME_WIDTH       = chtc_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              cal_valid,
  input  logic                              cal_keep,
  input  logic                              cal_back,
  input  logic [ENERGY_FRAC_BITS+20:0]      cal_energy,
  input  logic [TIME_WIDTH-1:0]             cal_time,
  input  logic [chtc_pkg::TAG_W-1:0]        cal_tag,
  input  logic                              cal_eoe,
  input  logic [chtc_pkg::HIT_TIME_W-1:0]   cluster_window,
  output chtc_pkg::result_pair_t            pair
);
  import chtc_pkg::*;

  localparam int CMP_W = cmp_width(TIME_WIDTH);

  // Cluster state.
  logic                  open;
  logic [TIME_WIDTH-1:0] start;
  logic [SUM_W-1:0]      back_sum;
  logic [SUM_W-1:0]      front_sum;
  logic [TAG_W-1:0]      open_event;

  logic                  open_next;
  logic [TIME_WIDTH-1:0] start_next;
  logic [SUM_W-1:0]      back_sum_next;
  logic [SUM_W-1:0]      front_sum_next;
  logic [TAG_W-1:0]      open_event_next;

  logic [CMP_W-1:0] t_c;
  logic [CMP_W-1:0] s_c;
  logic             join_hit;
  logic             close_hit;
  logic             flush;
  logic [SUM_W-1:0] base_back;
  logic [SUM_W-1:0] base_front;
  result_t          close_res;
  result_t          flush_res;

  // A hit earlier than the start counts as inside the window.
  assign t_c       = CMP_W'(cal_time);
  assign s_c       = CMP_W'(start);
  assign join_hit  = open && (cal_tag == open_event)
                  && ((t_c < s_c) || ((t_c - s_c) < CMP_W'(cluster_window)));
  assign close_hit = cal_keep && !join_hit && open;

  // State after the hit, before any end-of-event flush.
  always_comb begin
    base_back       = back_sum;
    base_front      = front_sum;
    start_next      = start;
    open_event_next = open_event;
    open_next       = open;
    if (cal_keep && !join_hit) begin
      base_back       = '0;
      base_front      = '0;
      start_next      = cal_time;
      open_event_next = cal_tag;
      open_next       = 1'b1;
    end
    back_sum_next  = base_back;
    front_sum_next = base_front;
    if (cal_keep) begin
      if (cal_back) begin
        back_sum_next = sat_add(base_back, SUM_W'(cal_energy));
      end else begin
        front_sum_next = sat_add(base_front, SUM_W'(cal_energy));
      end
    end
  end

  assign flush = cal_eoe && open_next;

  // The cluster closed by the hit, then the one flushed by the end mark.
  always_comb begin
    close_res.cluster_time  = HIT_TIME_W'(start);
    close_res.back_energy   = back_sum;
    close_res.front_energy  = front_sum;
    close_res.cluster_event = open_event;
    close_res.last_of_run   = !flush;

    flush_res.cluster_time  = HIT_TIME_W'(start_next);
    flush_res.back_energy   = back_sum_next;
    flush_res.front_energy  = front_sum_next;
    flush_res.cluster_event = open_event_next;
    flush_res.last_of_run   = 1'b1;

    pair.first  = close_hit ? close_res : flush_res;
    pair.second = flush_res;
    pair.count  = '0;
    if (advance && cal_valid) begin
      pair.count = {1'b0, close_hit} + {1'b0, flush};
    end
  end

  // State register; the end mark clears everything.
  always_ff @(posedge clk) begin
    if (rst) begin
      open       <= 1'b0;
      start      <= '0;
      back_sum   <= '0;
      front_sum  <= '0;
      open_event <= '0;
    end else if (advance && cal_valid) begin
      if (flush) begin
        open       <= 1'b0;
        start      <= '0;
        back_sum   <= '0;
        front_sum  <= '0;
        open_event <= '0;
      end else begin
        open       <= open_next;
        start      <= start_next;
        back_sum   <= back_sum_next;
        front_sum  <= front_sum_next;
        open_event <= open_event_next;
      end
    end
  end

endmodule

// ===== rtl/core/chtc_out_fifo.sv =====
// Small result queue: up to two clusters in a cycle, one out unless stalled.
module chtc_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  chtc_pkg::result_pair_t pair,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_stall,
  output chtc_pkg::result_t      head
);
  import chtc_pkg::*;

  result_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_PTR_W-1:0] wr_ptr_1;
  logic                  pop;

  assign wr_ptr_1  = wr_ptr + FIFO_PTR_W'(1);
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  // Room for the worst case of two clusters from one hit.
  assign space = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(pair.count);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count + FIFO_CNT_W'(pair.count) - FIFO_CNT_W'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (pair.count != 2'd0) begin
      entries[wr_ptr] <= pair.first;
    end
    if (pair.count == 2'd2) begin
      entries[wr_ptr_1] <= pair.second;
    end
  end

endmodule

// ===== tb/chtc_tb_pkg.sv =====
// Cluster prediction and result checking for the hit time clusterer testbench.
package chtc_tb_pkg;
  import chtc_pkg::*;

  // Calibration in hundredths: back channels 1-10, front 17-23, then the default front entry.
  localparam int unsigned GAIN_CENTI [18] = '{
    174, 194, 182, 186, 188, 265, 192, 200, 210, 252,
    190, 181, 190, 200, 196, 195, 180, 194
  };
  localparam int unsigned OFFSET_CENTI [18] = '{
    1246, 1034, 1170, 2230, 2078, 1341, 1303, 1492, 1337, 1316,
    2451, 3433, 3227, 5030, 8273, 3343, 3241, 2770
  };
  localparam int DEFAULT_SLOT = 17;

  // First register index past the end of the register list; such writes are ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;

  // Tracks the open cluster the way the block should and holds the clusters still owed.
  class cluster_tracker;
    logic [HIT_TIME_W-1:0] gate_low;
    logic [HIT_TIME_W-1:0] gate_high;
    logic [HIT_TIME_W-1:0] window;
    logic [FLOOR_W-1:0]    energy_floor;
    logic [RAW_W-1:0]      raw_limit;

    bit                    cluster_is_open;
    logic [HIT_TIME_W-1:0] start_time;
    logic [SUM_W-1:0]      back_sum;
    logic [SUM_W-1:0]      front_sum;
    logic [TAG_W-1:0]      open_tag;

    result_t expected_clusters[$];
    int      mismatches;

    function new();
      gate_low        = TIME_GATE_LOW_RST;
      gate_high       = TIME_GATE_HIGH_RST;
      window          = CLUSTER_WINDOW_RST;
      energy_floor    = ENERGY_FLOOR_RST;
      raw_limit       = RAW_LIMIT_RST;
      mismatches      = 0;
      clear_cluster();
    endfunction

    function void clear_cluster();
      cluster_is_open = 1'b0;
      start_time      = '0;
      back_sum        = '0;
      front_sum       = '0;
      open_tag        = '0;
    endfunction

    // A register write keeps only the bits of that register.
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TIME_GATE_LOW:  gate_low     = data[HIT_TIME_W-1:0];
        REG_TIME_GATE_HIGH: gate_high    = data[HIT_TIME_W-1:0];
        REG_CLUSTER_WINDOW: window       = data[HIT_TIME_W-1:0];
        REG_ENERGY_FLOOR:   energy_floor = data[FLOOR_W-1:0];
        REG_RAW_LIMIT:      raw_limit    = data[RAW_W-1:0];
        default: ;
      endcase
    endfunction

    // Calibrated energy in sixteenths of keV, with gain and offset rounded half up.
    function logic [63:0] energy_of(logic [RAW_W-1:0] raw, logic [CHANNEL_W-1:0] ch);
      int          slot;
      logic [63:0] gq;
      logic [63:0] oq;
      logic [63:0] prod;
      if (ch >= 1 && ch <= 10) begin
        slot = int'(ch) - 1;
      end else if (ch >= 17 && ch <= 23) begin
        slot = int'(ch) - 7;
      end else begin
        slot = DEFAULT_SLOT;
      end
      gq   = ((64'(GAIN_CENTI[slot]) << GAIN_FRAC_BITS_DEF) + 64'd50) / 64'd100;
      oq   = ((64'(OFFSET_CENTI[slot]) << ENERGY_FRAC_BITS_DEF) + 64'd50) / 64'd100;
      prod = (64'(raw) * gq) << ENERGY_FRAC_BITS_DEF;
      return ((prod + (64'd1 << (GAIN_FRAC_BITS_DEF - 1))) >> GAIN_FRAC_BITS_DEF) + oq;
    endfunction

    function logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] a, logic [63:0] b);
      logic [63:0] s;
      s = 64'(a) + b;
      return (s > 64'hFFFF_FFFF) ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function result_t snapshot();
      result_t r;
      r.cluster_time  = start_time;
      r.back_energy   = back_sum;
      r.front_energy  = front_sum;
      r.cluster_event = open_tag;
      r.last_of_run   = 1'b0;
      return r;
    endfunction

    function int pending();
      return expected_clusters.size();
    endfunction

    // Works out the clusters that one accepted hit closes or flushes.
    function void note_hit(logic [HIT_TIME_W-1:0] t, logic [RAW_W-1:0] raw,
                           logic [CHANNEL_W-1:0] ch, logic [TAG_W-1:0] tag, logic eoe);
      logic [63:0] e;
      logic        is_back;
      logic        joins;
      result_t     made [2];
      int          n;
      int          k;
      n = 0;
      if (raw < raw_limit) begin
        e       = energy_of(raw, ch);
        is_back = (ch >= 1 && ch <= 10);
        if (t > gate_low && t <= gate_high && e > 64'(energy_floor)) begin
          // A hit earlier than the cluster start still counts as inside the window.
          joins = 1'b0;
          if (cluster_is_open && tag == open_tag) begin
            joins = (t < start_time) || ((t - start_time) < window);
          end
          if (!joins) begin
            if (cluster_is_open) begin
              made[n] = snapshot();
              n++;
            end
            cluster_is_open = 1'b1;
            start_time      = t;
            open_tag        = tag;
            back_sum        = '0;
            front_sum       = '0;
          end
          if (is_back) begin
            back_sum = sum_sat(back_sum, e);
          end else begin
            front_sum = sum_sat(front_sum, e);
          end
        end
      end
      // The end mark flushes whatever is open, even when the hit itself was dropped.
      if (eoe && cluster_is_open) begin
        made[n] = snapshot();
        n++;
        clear_cluster();
      end
      if (n > 0) begin
        made[n-1].last_of_run = 1'b1;
      end
      for (k = 0; k < n; k++) begin
        expected_clusters.insert(expected_clusters.size(), made[k]);
      end
    endfunction

    // Compares one cluster from the block with the oldest one owed.
    function void check_cluster(result_t got);
      result_t want;
      if (expected_clusters.size() == 0) begin
        $error("unexpected cluster: cluster_time %0d cluster_event %0d",
               got.cluster_time, got.cluster_event);
        mismatches++;
        return;
      end
      want = expected_clusters.pop_front();
      if (got.cluster_time !== want.cluster_time) begin
        $error("cluster_time: expected %0d, actual %0d", want.cluster_time, got.cluster_time);
        mismatches++;
      end
      if (got.back_energy !== want.back_energy) begin
        $error("back_energy: expected %0d, actual %0d", want.back_energy, got.back_energy);
        mismatches++;
      end
      if (got.front_energy !== want.front_energy) begin
        $error("front_energy: expected %0d, actual %0d", want.front_energy, got.front_energy);
        mismatches++;
      end
      if (got.cluster_event !== want.cluster_event) begin
        $error("cluster_event: expected %0d, actual %0d", want.cluster_event,
               got.cluster_event);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top of the hit time clusterer testbench: clock, reset, hit sender, cluster receiver.
module tb_top;
  import chtc_pkg::*;
  import chtc_tb_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 6;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [HIT_TIME_W-1:0]  hit_time;
  logic [RAW_W-1:0]       raw_energy;
  logic [CHANNEL_W-1:0]   channel;
  logic [TAG_W-1:0]       event_tag;
  logic                   end_of_event;
  logic                   out_valid;
  logic                   out_stall;
  logic [HIT_TIME_W-1:0]  cluster_time;
  logic [SUM_W-1:0]       back_energy;
  logic [SUM_W-1:0]       front_energy;
  logic [TAG_W-1:0]       cluster_event;
  logic                   last_of_run;

  cluster_tracker sb;
  bit             tx_idle_en;
  bit             rx_idle_en;
  int             hold_request;
  int             hold_left;
  int             stall_left;
  int             hits_sent;
  int             quiet_cycles;

  calibrated_hit_time_clusterer_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .hit_time      (hit_time),
    .raw_energy    (raw_energy),
    .channel       (channel),
    .event_tag     (event_tag),
    .end_of_event  (end_of_event),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cluster_time  (cluster_time),
    .back_energy   (back_energy),
    .front_energy  (front_energy),
    .cluster_event (cluster_event),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: checks each accepted cluster, then picks the stall for the next cycle.
  initial begin
    out_stall <= 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_cluster(result_t'({cluster_time, back_energy, front_energy,
                                    cluster_event, last_of_run}));
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(5, 0) == 0) begin
        stall_left = $urandom_range(7, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any item, cluster or register write moving ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no progress for %0d cycles, %0d clusters still owed", quiet_cycles,
             sb.pending());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one hit, with an optional gap first, and waits until it is taken.
  task automatic send_hit(input logic [HIT_TIME_W-1:0] t, input logic [RAW_W-1:0] raw,
                          input logic [CHANNEL_W-1:0] ch, input logic [TAG_W-1:0] tag,
                          input logic eoe);
    if (tx_idle_en && $urandom_range(5, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    hit_time     <= t;
    raw_energy   <= raw;
    channel      <= ch;
    event_tag    <= tag;
    end_of_event <= eoe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_hit(t, raw, ch, tag, eoe);
    hits_sent++;
  endtask

  // Stops sending and waits for every owed cluster plus the pipeline latency.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Loads a full register setting on an idle block; spare indexes get junk.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                               input logic [CFG_DATA_W-1:0] win,
                               input logic [CFG_DATA_W-1:0] floor_kev16,
                               input logic [CFG_DATA_W-1:0] limit);
    int i;
    settle();
    write_cfg(REG_TIME_GATE_LOW, lo);
    write_cfg(REG_TIME_GATE_HIGH, hi);
    write_cfg(REG_CLUSTER_WINDOW, win);
    write_cfg(REG_ENERGY_FLOOR, floor_kev16);
    write_cfg(REG_RAW_LIMIT, limit);
    for (i = REG_SPARE_FIRST; i < (1 << CFG_INDEX_W); i++) begin
      write_cfg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
    end
    cfg_write <= 1'b0;
  endtask

  // One event of time-ordered hits, with occasional noise, jumps and tag changes.
  task automatic run_event(input int hits);
    logic [HIT_TIME_W-1:0] t;
    logic [TAG_W-1:0]      tag;
    logic [RAW_W-1:0]      raw;
    logic                  eoe;
    int                    w;
    int                    nt;
    int                    k;
    w   = int'(sb.window);
    tag = TAG_W'($urandom);
    if (sb.gate_high > sb.gate_low) begin
      t = HIT_TIME_W'($urandom_range(int'(sb.gate_high), int'(sb.gate_low) + 1));
    end else begin
      t = HIT_TIME_W'($urandom);
    end
    for (k = 0; k < hits; k++) begin
      case ($urandom_range(15, 0))
        0:       raw = RAW_W'($urandom);
        1:       raw = ($urandom_range(1, 0) == 0 || sb.raw_limit == 0) ?
                       sb.raw_limit : sb.raw_limit - 1'b1;
        default: raw = RAW_W'($urandom_range(3000, 0));
      endcase
      if ($urandom_range(15, 0) == 0) begin
        t = HIT_TIME_W'($urandom);
      end else if (k > 0) begin
        if ($urandom_range(3, 0) == 0) begin
          nt = int'(t) + $urandom_range(2 * w + 1, 0);
        end else begin
          nt = int'(t) + $urandom_range(w / 3 + 1, 0);
        end
        t = (nt > 65535) ? 16'hFFFF : HIT_TIME_W'(nt);
      end
      if ($urandom_range(19, 0) == 0) begin
        tag = TAG_W'($urandom);
      end
      eoe = (k == hits - 1) || ($urandom_range(30, 0) == 0);
      send_hit(t, raw, CHANNEL_W'($urandom_range(31, 0)), tag, eoe);
    end
  endtask

  task automatic run_phase(input int hit_budget);
    int first;
    first = hits_sent;
    while (hits_sent - first < hit_budget) begin
      run_event($urandom_range(12, 1));
    end
  endtask

  initial begin
    sb = new();
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    hit_time     <= '0;
    raw_energy   <= '0;
    channel      <= '0;
    event_tag    <= '0;
    end_of_event <= 1'b0;
    quiet_cycles <= 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_request = 0;
    hits_sent    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers: join, time going backwards, window edge, raw limit edge,
    // tag change, dropped hit with end mark, empty event, gate edges.
    send_hit(16'd150, 17'd1000, 5'd1, 16'd5, 1'b0);
    send_hit(16'd170, 17'd2000, 5'd17, 16'd5, 1'b0);
    send_hit(16'd140, 17'd500, 5'd24, 16'd5, 1'b0);
    send_hit(16'd210, 17'd800, 5'd0, 16'd5, 1'b0);
    send_hit(16'd215, 17'd99999, 5'd10, 16'd5, 1'b0);
    send_hit(16'd216, 17'd100000, 5'd10, 16'd5, 1'b0);
    send_hit(16'd220, 17'd300, 5'd31, 16'd9, 1'b0);
    send_hit(16'd100, 17'd500, 5'd2, 16'd9, 1'b1);
    send_hit(16'd150, 17'd0, 5'd3, 16'd1, 1'b1);
    send_hit(16'd2000, 17'd400, 5'd5, 16'd2, 1'b0);
    send_hit(16'd2001, 17'd400, 5'd5, 16'd2, 1'b0);
    send_hit(16'd101, 17'd400, 5'd4, 16'd2, 1'b1);
    // A hit that closes one cluster and flushes the one it opens.
    send_hit(16'd300, 17'd1000, 5'd2, 16'd7, 1'b0);
    send_hit(16'd305, 17'd1000, 5'd18, 16'd8, 1'b1);

    // Full gate, zero window, floor set exactly at one hit's energy.
    apply_setting(24'd0, 24'hFFFF, 24'd0, 24'(sb.energy_of(17'd1000, 5'd7)), 24'h1FFFF);
    send_hit(16'd0, 17'd1000, 5'd7, 16'hFFFF, 1'b0);
    send_hit(16'hFFFF, 17'd1000, 5'd7, 16'hFFFF, 1'b0);
    send_hit(16'hFFFF, 17'd1001, 5'd7, 16'hFFFF, 1'b0);
    send_hit(16'hFFFF, 17'h1FFFF, 5'd6, 16'hFFFF, 1'b0);
    send_hit(16'hFFFF, 17'h1FFFE, 5'd20, 16'hFFFF, 1'b1);

    // Empty or inverted gates drop everything.
    apply_setting(24'd500, 24'd500, 24'd60, 24'd0, 24'h1FFFF);
    send_hit(16'd500, 17'd100, 5'd1, 16'd3, 1'b1);
    send_hit(16'd501, 17'd100, 5'd17, 16'd3, 1'b1);
    apply_setting(24'd600, 24'd400, 24'd60, 24'd0, 24'h1FFFF);
    send_hit(16'd500, 17'd100, 5'd1, 16'd3, 1'b1);

    // Random events under several register settings.
    apply_setting(24'(TIME_GATE_LOW_RST), 24'(TIME_GATE_HIGH_RST), 24'(CLUSTER_WINDOW_RST),
                  24'(ENERGY_FLOOR_RST), 24'(RAW_LIMIT_RST));
    run_phase(70);
    apply_setting(24'd0, 24'hFFFF, 24'($urandom_range(300, 1)), 24'($urandom_range(2000, 0)),
                  24'h1FFFF);
    run_phase(70);
    // Zero window makes nearly every hit a cluster; the receiver holds off meanwhile.
    apply_setting(24'($urandom_range(500, 0)), 24'hFFFF, 24'd0, 24'd1000, 24'h1FFFF);
    hold_request = LONG_HOLD;
    run_phase(70);
    apply_setting(24'($urandom_range(200, 0)), 24'hFFFF, 24'hFFFF, 24'd0,
                  24'($urandom_range(131071, 0)));
    run_phase(70);
    apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    run_phase(70);
    apply_setting(24'd0, 24'hFFFF, 24'd40, 24'hFFFFFF, 24'd0);
    run_phase(20);
    apply_setting(24'($urandom_range(1000, 0)), 24'($urandom_range(65535, 30000)),
                  24'($urandom_range(1000, 1)), 24'($urandom_range(4000, 0)),
                  24'($urandom_range(131071, 50000)));
    run_phase(70);

    // Closing stretch at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    apply_setting(24'd50, 24'd60000, 24'($urandom_range(400, 20)), 24'd800, 24'h1FFFF);
    run_phase(60);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== calibrated_hit_time_clusterer_core.f =====
rtl/core/chtc_pkg.sv
rtl/core/chtc_calib.sv
rtl/core/chtc_cluster.sv
rtl/core/chtc_out_fifo.sv
rtl/core/calibrated_hit_time_clusterer_core.sv
tb/chtc_tb_pkg.sv
tb/tb_top.sv
